### rtl/core/pngu_pkg.sv
// shared types and constants for the png scanline unfilter
package pngu_pkg;

    localparam int ROW_BYTES_W = 17;
    localparam int BPP_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 17;
    localparam int FILTER_MAX  = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BPP       = 1'b1;

    typedef enum logic [2:0] {
        F_NONE  = 3'd0,
        F_SUB   = 3'd1,
        F_UP    = 3'd2,
        F_AVG   = 3'd3,
        F_PAETH = 3'd4
    } t_filter;

    // what a beat turns into once it reaches the reconstruction stage
    typedef enum logic [1:0] {
        K_FILT = 2'd0,
        K_DATA = 2'd1,
        K_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        t_filter    filt;
        logic       use_b;
        logic       last;
    } t_item;

endpackage

### rtl/core/pngu_if.sv
// valid/ready channel interfaces for stream in, stream out and configuration
interface pngu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       pass_start;
    modport source (output valid, output data_byte, output pass_start, input ready);
    modport sink   (input valid, input data_byte, input pass_start, output ready);
endinterface

interface pngu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] value;
    logic       last_of_row;
    logic       bad_filter;
    modport source (output valid, output value, output last_of_row, output bad_filter,
                    input ready);
    modport sink   (input valid, input value, input last_of_row, input bad_filter,
                    output ready);
endinterface

interface pngu_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [16:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/png_scanline_unfilter_core.sv
// png scanline unfilter top level: row tracking, prior row memory, reconstruction
// a data or bad filter beat loads the recon stage as it is accepted (a data beat also
// issues its prior row read), then the output register once that register is free;
// filter beats give no result
// throughput: one stream byte per cycle while the output register is not stalled
// reset: synchronous active low; clears row tracking, windows, pipeline valids and
// configuration (row_bytes 1, bytes_per_pixel 1); the prior row memory is not cleared
module png_scanline_unfilter_core
    import pngu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pngu_in_if.sink   i_in,
    pngu_out_if.source o_out,
    pngu_cfg_if.sink  i_cfg
);

    // prior row address width and row length compare width
    localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int LWR = $clog2(MAX_ROW_BYTES + 1);
    localparam int LW  = (LWR > ROW_BYTES_W) ? LWR : ROW_BYTES_W;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    logic [ROW_BYTES_W-1:0] r_row_bytes;
    logic [BPP_W-1:0]       r_bpp;

    logic          in_fire;
    logic          load;
    t_item         item;
    logic [AW-1:0] rd_addr;
    logic          recon_ready;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    rd_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= ROW_BYTES_W'(1);
            r_bpp       <= BPP_W'(1);
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_IDX_ROW_BYTES) begin
                r_row_bytes <= i_cfg.data;
            end else if (i_cfg.index == CFG_IDX_BPP) begin
                r_bpp <= i_cfg.data[BPP_W-1:0];
            end
        end
    end

    // every beat, ignored ones too, waits for room in the reconstruction stage
    assign i_in.ready = recon_ready;
    assign in_fire    = i_in.valid && recon_ready;

    pngu_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .AW            (AW),
        .LW            (LW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_data      (i_in.data_byte),
        .i_start     (i_in.pass_start),
        .i_row_bytes (r_row_bytes),
        .o_load      (load),
        .o_item      (item),
        .o_pos       (rd_addr)
    );

    // the read for a byte is issued as it is accepted; the write for the same
    // position in the previous row retired at least one filter beat earlier,
    // so read and write of one entry never overlap and no bypass is needed
    pngu_prior_mem #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (load && item.kind == K_DATA),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // predictor, left and upper-left windows, output register
    pngu_recon #(
        .AW (AW)
    ) u_recon (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_item      (item),
        .i_pos       (rd_addr),
        .i_rd_data   (rd_data),
        .i_bpp       (r_bpp),
        .o_ready     (recon_ready),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_valid     (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_value     (o_out.value),
        .o_last      (o_out.last_of_row),
        .o_bad       (o_out.bad_filter)
    );

endmodule

### rtl/core/pngu_prior_mem.sv
// prior row store: one write port, one registered read port
module pngu_prior_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the stage that uses it is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/pngu_front.sv
// row tracking: filter byte decode, byte position, prior row read issue
module pngu_front
    import pngu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 65536,
    parameter int AW            = 16,
    parameter int LW            = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_data,
    input  logic                   i_start,
    input  logic [ROW_BYTES_W-1:0] i_row_bytes,
    output logic                   o_load,
    output t_item                  o_item,
    output logic [AW-1:0]          o_pos
);

    logic          r_in_row,     n_in_row;
    logic [AW-1:0] r_pos,        n_pos;
    t_filter       r_filter,     n_filter;
    logic          r_have_prior, n_have_prior;
    logic          r_err_hold,   n_err_hold;

    logic [LW-1:0] row_len_raw;
    logic [LW-1:0] row_len;
    logic          is_last;

    // zero acts as one, oversized saturates
    always_comb begin
        row_len_raw = LW'(i_row_bytes);
        if (row_len_raw == '0) begin
            row_len = LW'(1);
        end else if (row_len_raw > LW'(MAX_ROW_BYTES)) begin
            row_len = LW'(MAX_ROW_BYTES);
        end else begin
            row_len = row_len_raw;
        end
    end

    assign is_last = (LW'(r_pos) + LW'(1)) >= row_len;

    always_comb begin
        n_in_row     = r_in_row;
        n_pos        = r_pos;
        n_filter     = r_filter;
        n_have_prior = r_have_prior;
        n_err_hold   = r_err_hold;
        o_load       = 1'b0;
        o_item       = '{kind: K_FILT, data: i_data, filt: r_filter,
                         use_b: r_have_prior, last: is_last};
        if (i_fire) begin
            if (i_start) begin
                n_in_row     = 1'b0;
                n_have_prior = 1'b0;
                n_err_hold   = 1'b0;
            end
            if (i_start || !r_err_hold) begin
                if (i_start || !r_in_row) begin
                    if (i_data > 8'(FILTER_MAX)) begin
                        n_err_hold  = 1'b1;
                        o_load      = 1'b1;
                        o_item.kind = K_ERR;
                    end else begin
                        n_filter    = t_filter'(i_data[2:0]);
                        n_in_row    = 1'b1;
                        n_pos       = '0;
                        o_load      = 1'b1;
                        o_item.kind = K_FILT;
                    end
                end else begin
                    o_load      = 1'b1;
                    o_item.kind = K_DATA;
                    if (is_last) begin
                        n_in_row     = 1'b0;
                        n_have_prior = 1'b1;
                    end else begin
                        n_pos = r_pos + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row     <= 1'b0;
            r_pos        <= '0;
            r_filter     <= F_NONE;
            r_have_prior <= 1'b0;
            r_err_hold   <= 1'b0;
        end else begin
            r_in_row     <= n_in_row;
            r_pos        <= n_pos;
            r_filter     <= n_filter;
            r_have_prior <= n_have_prior;
            r_err_hold   <= n_err_hold;
        end
    end

    assign o_pos = r_pos;

endmodule

### rtl/core/pngu_recon.sv
// reconstruction stage: predictor, neighbor windows, write back, output register
module pngu_recon
    import pngu_pkg::*;
#(
    parameter int AW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_item            i_item,
    input  logic [AW-1:0]    i_pos,
    input  logic [7:0]       i_rd_data,
    input  logic [BPP_W-1:0] i_bpp,
    output logic             o_ready,
    output logic             o_we,
    output logic [AW-1:0]    o_waddr,
    output logic [7:0]       o_wdata,
    output logic             o_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_value,
    output logic             o_last,
    output logic             o_bad
);

    logic            r_v;
    t_item           r_item;
    logic [AW-1:0]   r_pos;
    logic [7:0][7:0] r_left,  n_left;
    logic [7:0][7:0] r_upleft, n_upleft;
    logic            r_ov,    n_ov;
    logic [7:0]      r_value, n_value;
    logic            r_last,  n_last;
    logic            r_bad,   n_bad;

    logic [2:0] dist_idx;
    logic [7:0] a_v, b_v, c_v, pred, val;
    logic [8:0] avg_sum;
    logic       fire;
    logic       out_free;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] p, da, db, dc;
        p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
        da = (p > $signed({2'b00, a})) ? p - $signed({2'b00, a}) : $signed({2'b00, a}) - p;
        db = (p > $signed({2'b00, b})) ? p - $signed({2'b00, b}) : $signed({2'b00, b}) - p;
        dc = (p > $signed({2'b00, c})) ? p - $signed({2'b00, c}) : $signed({2'b00, c}) - p;
        if (da <= db && da <= dc) begin
            return a;
        end else if (db <= dc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

    // filter distance clamped to 1..8
    always_comb begin
        if (i_bpp == '0) begin
            dist_idx = 3'd0;
        end else if (i_bpp > BPP_W'(8)) begin
            dist_idx = 3'd7;
        end else begin
            dist_idx = 3'(i_bpp - BPP_W'(1));
        end
    end

    assign a_v     = r_left[dist_idx];
    assign c_v     = r_upleft[dist_idx];
    assign b_v     = r_item.use_b ? i_rd_data : 8'd0;
    assign avg_sum = {1'b0, a_v} + {1'b0, b_v};

    always_comb begin
        unique case (r_item.filt)
            F_NONE:  pred = 8'd0;
            F_SUB:   pred = a_v;
            F_UP:    pred = b_v;
            F_AVG:   pred = avg_sum[8:1];
            F_PAETH: pred = paeth(a_v, b_v, c_v);
            default: pred = 8'd0;
        endcase
    end

    assign val = r_item.data + pred;

    // filter beats retire without touching the output register
    assign out_free = !r_ov || i_out_ready;
    assign fire     = r_v && (r_item.kind == K_FILT || out_free);
    assign o_ready  = !r_v || fire;

    assign o_we    = fire && r_item.kind == K_DATA;
    assign o_waddr = r_pos;
    assign o_wdata = val;

    always_comb begin
        n_left   = r_left;
        n_upleft = r_upleft;
        n_ov     = r_ov && !i_out_ready;
        n_value  = r_value;
        n_last   = r_last;
        n_bad    = r_bad;
        if (fire) begin
            unique case (r_item.kind)
                K_FILT: begin
                    n_left   = '0;
                    n_upleft = '0;
                end
                K_DATA: begin
                    n_left   = {r_left[6:0], val};
                    n_upleft = {r_upleft[6:0], b_v};
                    n_ov     = 1'b1;
                    n_value  = val;
                    n_last   = r_item.last;
                    n_bad    = 1'b0;
                end
                K_ERR: begin
                    n_ov    = 1'b1;
                    n_value = 8'd0;
                    n_last  = 1'b0;
                    n_bad   = 1'b1;
                end
                default: begin
                    n_ov = r_ov && !i_out_ready;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= 1'b0;
            r_ov     <= 1'b0;
            r_left   <= '0;
            r_upleft <= '0;
        end else begin
            r_v      <= i_load || (r_v && !fire);
            r_ov     <= n_ov;
            r_left   <= n_left;
            r_upleft <= n_upleft;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
            r_pos  <= i_pos;
        end
        r_value <= n_value;
        r_last  <= n_last;
        r_bad   <= n_bad;
    end

    assign o_valid = r_ov;
    assign o_value = r_value;
    assign o_last  = r_last;
    assign o_bad   = r_bad;

endmodule

### rtl/core/pngu_checker.sv
// port-level checks for the unfilter core, bound to the top level
module pngu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_value,
    input logic       i_out_last,
    input logic       i_out_bad
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_last) && $stable(i_out_bad))
        else $error("output beat changed while stalled");

    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad |-> i_out_value == 8'd0 && !i_out_last)
        else $error("error beat carries data or row end");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // the reconstruction stage is empty after reset, so the input takes a beat
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready right after reset");

endmodule

bind png_scanline_unfilter_core pngu_checker u_pngu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value),
    .i_out_last  (o_out.last_of_row),
    .i_out_bad   (o_out.bad_filter)
);

### test/tb_png_scanline_unfilter_core.sv
// self-checking testbench for png_scanline_unfilter_core: directed and random scanline streams
`timescale 1ns / 1ps

module tb_png_scanline_unfilter_core;
    import pngu_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int MAX_ROW      = 65536;
    localparam int RANDOM_ITEMS = 900;
    localparam int LIMIT_CYCLES = 2_000_000;
    // margin that settle waits once every expected beat has come out
    localparam int SETTLE_CYCLES = 6;

    // one reconstructed output beat as the checker sees it
    typedef struct packed {
        logic [7:0] value;
        logic       last_of_row;
        logic       bad_filter;
    } t_out_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pngu_in_if  in_ch ();
    pngu_out_if out_ch ();
    pngu_cfg_if cfg_ch ();

    png_scanline_unfilter_core #(
        .MAX_ROW_BYTES(MAX_ROW)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // unfilter predictor state, mirrors what the block should hold
    // ------------------------------------------------------------------
    logic [16:0] cfg_row_bytes;
    logic [3:0]  cfg_bpp;
    logic [7:0]  prior_mem [0:MAX_ROW-1];
    bit          prior_ok;      // a full row of this pass has been rebuilt
    t_filter     cur_filter;
    int unsigned row_pos;       // 0: filter byte due, k: data byte k due
    logic [63:0] left_hist;     // rebuilt bytes of this row, newest low
    logic [63:0] above_hist;    // above bytes used so far, newest low
    bit          halted;        // dropping bytes after a bad filter type

    t_out_beat rebuilt_q [$];   // expected output beats, oldest first

    int  error_count = 0;
    int  fed_count;             // accepted beats that the block acts on
    bit  gaps_on;               // random idling on both channels
    int  stall_left;
    t_out_beat want_beat;

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // row length as the block uses it: zero acts as one, big values clamp
    function automatic int unsigned row_len();
        if (cfg_row_bytes == 0) return 1;
        if (cfg_row_bytes > MAX_ROW) return MAX_ROW;
        return 32'(cfg_row_bytes);
    endfunction

    function automatic logic [7:0] paeth_choice(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        int p, pa, pb, pc;
        p  = int'(a) + int'(b) - int'(c);
        pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
        pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
        pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
        if (pa <= pb && pa <= pc) return a;
        if (pb <= pc) return b;
        return c;
    endfunction

    // advance the predictor by one accepted stream beat, queue what it yields
    function automatic void unfilter_byte(logic [7:0] b, logic s);
        int unsigned span, idx, sh;
        logic [7:0]  a, up, ul, pred, val;
        logic [8:0]  sum9;
        bit          last;
        span = (cfg_bpp == 0) ? 1 : ((cfg_bpp > 8) ? 8 : 32'(cfg_bpp));

        // a pass start drops all row history, even mid-row
        if (s) begin
            prior_ok   = 1'b0;
            halted     = 1'b0;
            row_pos    = 0;
            left_hist  = '0;
            above_hist = '0;
        end
        if (halted) return;

        if (row_pos == 0) begin
            if (b > FILTER_MAX) begin
                halted = 1'b1;
                rebuilt_q.push_back('{value: 8'd0, last_of_row: 1'b0, bad_filter: 1'b1});
                return;
            end
            cur_filter = t_filter'(b[2:0]);
            row_pos    = 1;
            left_hist  = '0;
            above_hist = '0;
            return;
        end

        idx = row_pos - 1;
        if (idx >= MAX_ROW) idx = MAX_ROW - 1;
        sh = (span - 1) * 8;
        a  = left_hist[sh +: 8];
        up = prior_ok ? prior_mem[idx] : 8'd0;
        ul = above_hist[sh +: 8];

        case (cur_filter)
            F_SUB:   pred = a;
            F_UP:    pred = up;
            F_AVG: begin
                sum9 = {1'b0, a} + {1'b0, up};
                pred = sum9[8:1];
            end
            F_PAETH: pred = paeth_choice(a, up, ul);
            default: pred = 8'd0;
        endcase
        val = b + pred;

        prior_mem[idx] = val;
        left_hist  = {left_hist[55:0], val};
        above_hist = {above_hist[55:0], up};

        // a shrunk row length ends the row at the first byte that reaches it
        last = (idx + 1) >= row_len();
        if (last) begin
            row_pos  = 0;
            prior_ok = 1'b1;
        end else begin
            row_pos = idx + 2;
        end
        rebuilt_q.push_back('{value: val, last_of_row: last, bad_filter: 1'b0});
    endfunction

    // ------------------------------------------------------------------
    // stream driver: valid only drops when a gap is wanted, so back to
    // back beats never see valid lowered and raised in one step
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.pass_start <= s;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        // beat taken at this edge
        if (s || !halted) fed_count++;
        unfilter_byte(b, s);
    endtask

    // data bytes lean on 0 and 255 so the averages and paeth ties get hit
    function automatic logic [7:0] next_data(bit extremes);
        int r;
        if (extremes) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    // filter byte plus one full row of data at the current row length
    task automatic send_row(input logic [7:0] filt, input logic s, input bit extremes);
        int unsigned n;
        send_byte(filt, s);
        n = row_len();
        for (int unsigned i = 0; i < n; i++) send_byte(next_data(extremes), 1'b0);
    endtask

    // stop the stream and let every pending beat come out
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (rebuilt_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register writes only go in with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_IDX_ROW_BYTES) cfg_row_bytes = val;
        else cfg_bpp = val[BPP_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // output side: random back pressure, checker on every taken beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            out_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if (gaps_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (rebuilt_q.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected beat: value %0d last %0d bad %0d",
                             out_ch.value, out_ch.last_of_row, out_ch.bad_filter);
                error_count++;
            end else begin
                want_beat = rebuilt_q.pop_front();
                if (out_ch.value !== want_beat.value) begin
                    if (error_count < 10)
                        $display("value mismatch: expected %0d, got %0d",
                                 want_beat.value, out_ch.value);
                    error_count++;
                end
                if (out_ch.last_of_row !== want_beat.last_of_row) begin
                    if (error_count < 10)
                        $display("last_of_row mismatch: expected %0d, got %0d",
                                 want_beat.last_of_row, out_ch.last_of_row);
                    error_count++;
                end
                if (out_ch.bad_filter !== want_beat.bad_filter) begin
                    if (error_count < 10)
                        $display("bad_filter mismatch: expected %0d, got %0d",
                                 want_beat.bad_filter, out_ch.bad_filter);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every filter type once across a short row, all-zero and all-one bytes but for paeth
    task automatic test_each_filter();
        write_reg(CFG_IDX_ROW_BYTES, 17'd4);
        write_reg(CFG_IDX_BPP, 17'd2);
        send_row(8'(F_NONE), 1'b1, 1'b1);
        send_row(8'(F_SUB), 1'b0, 1'b1);
        send_row(8'(F_UP), 1'b0, 1'b1);
        send_row(8'(F_AVG), 1'b0, 1'b1);
        send_row(8'(F_PAETH), 1'b0, 1'b0);
    endtask

    // bad filter type gives one error beat, then silence until a pass start
    task automatic test_bad_filter();
        write_reg(CFG_IDX_ROW_BYTES, 17'd3);
        send_byte(8'(FILTER_MAX + 1), 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'(F_SUB), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h42, 1'b0);
        send_row(8'(F_PAETH), 1'b1, 1'b0);
    endtask

    // pass start in the middle of a row restarts framing with no row above
    task automatic test_pass_restart();
        write_reg(CFG_IDX_ROW_BYTES, 17'd6);
        send_row(8'(F_SUB), 1'b1, 1'b0);
        send_byte(8'(F_UP), 1'b0);
        repeat (3) send_byte(next_data(1'b0), 1'b0);
        send_row(8'(F_UP), 1'b1, 1'b0);
        send_row(8'(F_AVG), 1'b0, 1'b0);
    endtask

    // row length cut while a row is open ends that row at the next byte
    task automatic test_row_shrink();
        write_reg(CFG_IDX_ROW_BYTES, 17'd10);
        write_reg(CFG_IDX_BPP, 17'd3);
        send_row(8'(F_SUB), 1'b1, 1'b0);
        send_byte(8'(F_UP), 1'b0);
        repeat (6) send_byte(next_data(1'b0), 1'b0);
        write_reg(CFG_IDX_ROW_BYTES, 17'd3);
        send_byte(next_data(1'b0), 1'b0);
        send_row(8'(F_AVG), 1'b0, 1'b0);
        send_row(8'(F_PAETH), 1'b0, 1'b0);
    endtask

    // zero length, zero and oversized distance, widest real distance
    task automatic test_config_limits();
        write_reg(CFG_IDX_ROW_BYTES, 17'd0);
        write_reg(CFG_IDX_BPP, 17'd0);
        send_row(8'(F_SUB), 1'b1, 1'b0);
        send_row(8'(F_PAETH), 1'b0, 1'b0);
        write_reg(CFG_IDX_ROW_BYTES, 17'd20);
        write_reg(CFG_IDX_BPP, 17'h1FFFF);
        send_row(8'(F_SUB), 1'b1, 1'b0);
        send_row(8'(F_PAETH), 1'b0, 1'b0);
        write_reg(CFG_IDX_BPP, 17'd8);
        send_row(8'(F_AVG), 1'b0, 1'b0);
        write_reg(CFG_IDX_ROW_BYTES, 17'd1);
        write_reg(CFG_IDX_BPP, 17'd1);
        send_row(8'(F_UP), 1'b1, 1'b0);
        send_row(8'(F_PAETH), 1'b0, 1'b0);
    endtask

    // random passes: mostly well formed rows, some bad filters, cut rows and noise
    task automatic test_random_stream();
        int goal, rows, k, r, n;
        logic [16:0] rb;
        logic [3:0]  bpp;
        goal = fed_count + RANDOM_ITEMS;
        while (fed_count < goal) begin
            if ($urandom_range(0, 7) != 0) begin
                r = $urandom_range(0, 99);
                if (r < 70) rb = 17'($urandom_range(1, 16));
                else if (r < 90) rb = 17'($urandom_range(17, 64));
                else if (r < 95) rb = 17'd0;
                else rb = 17'($urandom_range(65, 300));
                r = $urandom_range(0, 99);
                if (r < 80) bpp = 4'($urandom_range(1, 8));
                else if (r < 90) bpp = 4'd0;
                else bpp = 4'($urandom_range(9, 15));
                write_reg(CFG_IDX_ROW_BYTES, rb);
                write_reg(CFG_IDX_BPP, {13'($urandom), bpp});
            end
            gaps_on = ($urandom_range(0, 4) != 0);
            rows = $urandom_range(1, 6);
            for (int i = 0; i < rows; i++) begin
                k = $urandom_range(0, 99);
                if (k < 85) begin
                    send_row(8'($urandom_range(F_NONE, F_PAETH)), i == 0, 1'b0);
                end else if (k < 92) begin
                    // bad filter, then bytes that must be dropped
                    send_byte(8'($urandom_range(FILTER_MAX + 1, 255)), i == 0);
                    n = $urandom_range(1, 5);
                    repeat (n) send_byte(8'($urandom), 1'b0);
                    break;
                end else if (k < 97) begin
                    // row cut short by a fresh pass
                    send_byte(8'($urandom_range(F_NONE, F_PAETH)), i == 0);
                    n = $urandom_range(0, row_len() - 1);
                    repeat (n) send_byte(next_data(1'b0), 1'b0);
                    send_row(8'($urandom_range(F_NONE, F_PAETH)), 1'b1, 1'b0);
                end else begin
                    // raw noise, framing lands wherever it lands; a new row
                    // length always opens with a pass start
                    n = $urandom_range(1, 8);
                    for (int j = 0; j < n; j++)
                        send_byte(8'($urandom), (i == 0 && j == 0) || 1'($urandom_range(0, 1)));
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'd0;
        in_ch.pass_start = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_IDX_ROW_BYTES;
        cfg_ch.data      = '0;
        cfg_row_bytes    = 17'd1;
        cfg_bpp          = 4'd1;
        prior_ok         = 1'b0;
        cur_filter       = F_NONE;
        row_pos          = 0;
        left_hist        = '0;
        above_hist       = '0;
        halted           = 1'b0;
        fed_count        = 0;
        gaps_on          = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_each_filter();
        test_bad_filter();
        test_pass_restart();
        test_row_shrink();
        test_config_limits();
        test_random_stream();

        settle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && rebuilt_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/pngu_pkg.sv
rtl/core/pngu_if.sv
rtl/core/pngu_prior_mem.sv
rtl/core/pngu_front.sv
rtl/core/pngu_recon.sv
rtl/core/png_scanline_unfilter_core.sv
rtl/core/pngu_checker.sv
test/tb_png_scanline_unfilter_core.sv
